>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros shared by the design files
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define SSLG_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SSLG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/sslg_pkg.sv
// ---------------------------------------------------------------------------
// sslg_pkg
// types, field constants and command codes for the share interpolator
// ---------------------------------------------------------------------------
package sslg_pkg;

   localparam int FE_W = 256;

   // field prime 2^256 - 2^32 - 977 and the inversion exponent p - 2
   localparam logic [FE_W-1:0] P_VAL =
      256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;
   localparam logic [FE_W-1:0] EXP_PM2 =
      256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2D;

   // status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_DUP   = 2'd2;
   localparam logic [1:0] ST_MANY  = 2'd3;

   // datapath operations
   typedef logic [3:0] op_type;
   localparam op_type OP_NONE    = 4'd0;
   localparam op_type OP_INIT_Y  = 4'd1;
   localparam op_type OP_INIT_ND = 4'd2;
   localparam op_type OP_LOAD_S  = 4'd3;
   localparam op_type OP_DIFF    = 4'd4;
   localparam op_type OP_ADD_Y   = 4'd5;
   localparam op_type OP_INIT_R  = 4'd6;
   localparam op_type OP_MUL_NUM = 4'd7;
   localparam op_type OP_MUL_DEN = 4'd8;
   localparam op_type OP_MUL_SN  = 4'd9;
   localparam op_type OP_MUL_T   = 4'd10;
   localparam op_type OP_MUL_SY  = 4'd11;
   localparam op_type OP_MUL_YD  = 4'd12;
   localparam op_type OP_MUL_RR  = 4'd13;
   localparam op_type OP_MUL_RY  = 4'd14;
   localparam op_type OP_MUL_YR  = 4'd15;

   typedef struct packed {
      logic [15:0] share_index;
      logic [63:0] limb_value;
      logic [1:0]  limb_number;
      logic        last_share;
   } req_type;

   typedef struct packed {
      logic [63:0] result_limb;
      logic [1:0]  result_limb_number;
      logic [1:0]  status;
      logic        last_limb;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic       mul_start;
      logic [1:0] limb;
      logic       val_we;
      logic       x_we;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic ge_p;
      logic dup;
   } stat_type;

   // field value of a - b for two 16-bit coordinates
   function automatic logic [FE_W-1:0] sub16(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] d;
      d = {1'b0, a} - {1'b0, b};
      return d[16] ? (P_VAL + {{(FE_W-17){1'b1}}, d}) : {{(FE_W-17){1'b0}}, d};
   endfunction

endpackage

>>> design/sslg_ram.sv
// ---------------------------------------------------------------------------
// sslg_ram
// simple dual-port RAM, one write and one registered read
// ---------------------------------------------------------------------------
module sslg_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> design/sslg_modmul.sv
// ---------------------------------------------------------------------------
// sslg_modmul
// bit-serial modular multiplier, one multiplier bit per cycle, msb first
// ---------------------------------------------------------------------------
module sslg_modmul (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sslg_pkg::FE_W-1:0]  a,
   input  logic [sslg_pkg::FE_W-1:0]  b,
   output logic                       done,
   output logic [sslg_pkg::FE_W-1:0]  prod
);

   localparam int W = sslg_pkg::FE_W;

   logic [W-1:0] a_ff, a_in;
   logic [W-1:0] b_ff, b_in;
   logic [W-1:0] r_ff, r_in;
   logic [7:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;

   logic [W+1:0] t;
   logic [W+2:0] t1, t2;

   // r = 2r + bit * a, then bring below p (sum stays below 3p)
   always_comb begin
      t  = {1'b0, r_ff, 1'b0} + (b_ff[W-1] ? {2'b0, a_ff} : '0);
      t1 = {1'b0, t} - {3'b0, sslg_pkg::P_VAL};
      t2 = {1'b0, t} - {2'b0, sslg_pkg::P_VAL, 1'b0};
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         r_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         priority if (!t2[W+2]) begin
            r_in = t2[W-1:0];
         end else if (!t1[W+2]) begin
            r_in = t1[W-1:0];
         end else begin
            r_in = t[W-1:0];
         end
         b_in   = {b_ff[W-2:0], 1'b0};
         cnt_in = cnt_ff + 8'd1;
         if (cnt_ff == 8'd255) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      a_ff <= a_in;
      b_ff <= b_in;
      r_ff <= r_in;
   end

   assign done = done_ff;
   assign prod = r_ff;

endmodule

>>> design/sslg_datapath.sv
// ---------------------------------------------------------------------------
// sslg_datapath
// share stores, field registers, modular multiplier and adders
// ---------------------------------------------------------------------------
module sslg_datapath #(
   parameter int MAX_SHARES = 64,
   parameter int IW = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [15:0]           csr_wdata,
   input  sslg_pkg::req_type     req,
   input  sslg_pkg::cmd_type     cmd,
   input  logic [IW-1:0]         wr_slot,
   input  logic [IW+1:0]         val_raddr,
   input  logic [IW-1:0]         x_raddr,
   output sslg_pkg::stat_type    stat,
   output logic [63:0]           res_limb
);

   localparam int W = sslg_pkg::FE_W;

   logic [15:0]  eval_ff;
   logic [W-1:0] s_ff, num_ff, den_ff, yn_ff, yd_ff, t_ff, rr_ff, da_ff, db_ff;
   logic [15:0]  xi_ff;
   sslg_pkg::op_type mul_op_ff;

   logic [63:0]  val_rdata;
   logic [15:0]  x_rdata;
   logic [W-1:0] mul_a, mul_b, prod;
   logic         mul_done;
   logic [W:0]   add_sum;
   logic [W+1:0] add_red;

   // share value and coordinate stores
   sslg_ram #(.WIDTH(64), .DEPTH(4 * MAX_SHARES), .ADDR_W(IW + 2)) u_val_ram (
      .clock (clock),
      .we    (cmd.val_we),
      .waddr ({wr_slot, req.limb_number}),
      .wdata (req.limb_value),
      .raddr (val_raddr),
      .rdata (val_rdata)
   );

   sslg_ram #(.WIDTH(16), .DEPTH(MAX_SHARES), .ADDR_W(IW)) u_x_ram (
      .clock (clock),
      .we    (cmd.x_we),
      .waddr (wr_slot),
      .wdata (req.share_index),
      .raddr (x_raddr),
      .rdata (x_rdata)
   );

   // multiplier operand selection
   always_comb begin
      unique case (cmd.op)
         sslg_pkg::OP_MUL_NUM: begin mul_a = num_ff; mul_b = da_ff; end
         sslg_pkg::OP_MUL_DEN: begin mul_a = den_ff; mul_b = db_ff; end
         sslg_pkg::OP_MUL_SN:  begin mul_a = s_ff;   mul_b = num_ff; end
         sslg_pkg::OP_MUL_T:   begin mul_a = yn_ff;  mul_b = den_ff; end
         sslg_pkg::OP_MUL_SY:  begin mul_a = s_ff;   mul_b = yd_ff; end
         sslg_pkg::OP_MUL_YD:  begin mul_a = yd_ff;  mul_b = den_ff; end
         sslg_pkg::OP_MUL_RR:  begin mul_a = rr_ff;  mul_b = rr_ff; end
         sslg_pkg::OP_MUL_RY:  begin mul_a = rr_ff;  mul_b = yd_ff; end
         sslg_pkg::OP_MUL_YR:  begin mul_a = yn_ff;  mul_b = rr_ff; end
         default:              begin mul_a = '0;     mul_b = '0; end
      endcase
   end

   sslg_modmul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (prod)
   );

   // modular add of the two accumulation terms
   always_comb begin
      add_sum = {1'b0, t_ff} + {1'b0, s_ff};
      add_red = {1'b0, add_sum} - {2'b0, sslg_pkg::P_VAL};
   end

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         eval_ff <= '0;
      end else if (csr_we) begin
         eval_ff <= csr_wdata;
      end
   end

   // field registers
   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         mul_op_ff <= cmd.op;
      end
      unique case (cmd.op)
         sslg_pkg::OP_INIT_Y: begin
            yn_ff <= '0;
            yd_ff <= W'(1);
         end
         sslg_pkg::OP_INIT_ND: begin
            num_ff <= W'(1);
            den_ff <= W'(1);
         end
         sslg_pkg::OP_LOAD_S: begin
            s_ff[cmd.limb * 64 +: 64] <= val_rdata;
            if (cmd.limb == 2'd0) begin
               xi_ff <= x_rdata;
            end
         end
         sslg_pkg::OP_DIFF: begin
            da_ff <= sslg_pkg::sub16(x_rdata, eval_ff);
            db_ff <= sslg_pkg::sub16(x_rdata, xi_ff);
         end
         sslg_pkg::OP_ADD_Y: begin
            yn_ff <= add_red[W+1] ? add_sum[W-1:0] : add_red[W-1:0];
         end
         sslg_pkg::OP_INIT_R: begin
            rr_ff <= W'(1);
         end
         default: begin
         end
      endcase
      // multiplier write-back
      if (mul_done) begin
         unique case (mul_op_ff)
            sslg_pkg::OP_MUL_NUM: num_ff <= prod;
            sslg_pkg::OP_MUL_DEN: den_ff <= prod;
            sslg_pkg::OP_MUL_SN:  s_ff   <= prod;
            sslg_pkg::OP_MUL_T:   t_ff   <= prod;
            sslg_pkg::OP_MUL_SY:  s_ff   <= prod;
            sslg_pkg::OP_MUL_YD:  yd_ff  <= prod;
            sslg_pkg::OP_MUL_RR:  rr_ff  <= prod;
            sslg_pkg::OP_MUL_RY:  rr_ff  <= prod;
            sslg_pkg::OP_MUL_YR:  yn_ff  <= prod;
            default: begin
            end
         endcase
      end
   end

   // status back to the controller
   always_comb begin
      stat.mul_done = mul_done;
      stat.ge_p     = (s_ff >= sslg_pkg::P_VAL);
      stat.dup      = (x_rdata == xi_ff);
   end

   assign res_limb = yn_ff[cmd.limb * 64 +: 64];

endmodule

>>> design/sslg_ctrl.sv
// ---------------------------------------------------------------------------
// sslg_ctrl
// load, interpolation and output sequencer
// ---------------------------------------------------------------------------
module sslg_ctrl #(
   parameter int MAX_SHARES = 64,
   parameter int IW = 6,
   parameter int CW = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sslg_pkg::req_type  req,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_limb_number,
   output logic [1:0]         rsp_status,
   output logic               rsp_last,
   input  sslg_pkg::stat_type stat,
   output sslg_pkg::cmd_type  cmd,
   output logic [IW-1:0]      wr_slot,
   output logic [IW+1:0]      val_raddr,
   output logic [IW-1:0]      x_raddr
);

   localparam logic [4:0] S_LOAD  = 5'd0;
   localparam logic [4:0] S_CHECK = 5'd1;
   localparam logic [4:0] S_SHARE = 5'd2;
   localparam logic [4:0] S_SRD   = 5'd3;
   localparam logic [4:0] S_JNEXT = 5'd4;
   localparam logic [4:0] S_JRD   = 5'd5;
   localparam logic [4:0] S_MNUM  = 5'd6;
   localparam logic [4:0] S_MDEN  = 5'd7;
   localparam logic [4:0] S_MSN   = 5'd8;
   localparam logic [4:0] S_MT    = 5'd9;
   localparam logic [4:0] S_MSY   = 5'd10;
   localparam logic [4:0] S_ADDY  = 5'd11;
   localparam logic [4:0] S_MYD   = 5'd12;
   localparam logic [4:0] S_INITR = 5'd13;
   localparam logic [4:0] S_MRR   = 5'd14;
   localparam logic [4:0] S_MRY   = 5'd15;
   localparam logic [4:0] S_MFIN  = 5'd16;
   localparam logic [4:0] S_OUT   = 5'd17;
   localparam logic [4:0] S_RSET  = 5'd18;
   localparam logic [4:0] S_RRD   = 5'd19;
   localparam logic [4:0] S_RCMP  = 5'd20;

   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SHARES);

   logic [4:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    err_ff, err_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [1:0]    k_ff, k_in;
   logic [7:0]    bit_ff, bit_in;
   logic          run_ff, run_in;
   logic          mul_fin;
   logic [CW-1:0] i_next;

   assign i_next = i_ff + CW'(1);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      err_in    = err_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      bit_in    = bit_ff;
      run_in    = run_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      mul_fin   = 1'b0;
      wr_slot   = count_ff[IW-1:0];
      val_raddr = {i_ff[IW-1:0], k_ff};
      x_raddr   = i_ff[IW-1:0];

      // shared multiply handshake: start once, then wait for done
      priority case (state_ff)
         S_MNUM, S_MDEN, S_MSN, S_MT, S_MSY, S_MYD, S_MRR, S_MRY, S_MFIN: begin
            if (!run_ff) begin
               cmd.mul_start = 1'b1;
               run_in        = 1'b1;
            end else if (stat.mul_done) begin
               run_in  = 1'b0;
               mul_fin = 1'b1;
            end
         end
         default: begin
         end
      endcase

      unique case (state_ff)
         // take share limbs
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff == MAX_CNT) begin
                  err_in = sslg_pkg::ST_MANY;
               end else begin
                  cmd.val_we = 1'b1;
                  if (req.limb_number == 2'd3) begin
                     cmd.x_we = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end
               if ((req.limb_number == 2'd3) && req.last_share) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            k_in = 2'd0;
            i_in = '0;
            if (err_ff != sslg_pkg::ST_OK) begin
               state_in = S_OUT;
            end else begin
               state_in = S_RSET;
            end
         end
         // range scan over the stored share values
         S_RSET: begin
            val_raddr = {i_ff[IW-1:0], 2'd0};
            k_in      = 2'd0;
            state_in  = S_RRD;
         end
         S_RRD: begin
            cmd.op    = sslg_pkg::OP_LOAD_S;
            cmd.limb  = k_ff;
            val_raddr = {i_ff[IW-1:0], k_ff + 2'd1};
            if (k_ff == 2'd3) begin
               state_in = S_RCMP;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_RCMP: begin
            if (stat.ge_p) begin
               err_in   = sslg_pkg::ST_RANGE;
               k_in     = 2'd0;
               state_in = S_OUT;
            end else if (i_next == count_ff) begin
               cmd.op   = sslg_pkg::OP_INIT_Y;
               i_in     = '0;
               state_in = S_SHARE;
            end else begin
               i_in     = i_next;
               state_in = S_RSET;
            end
         end
         // fetch share i
         S_SHARE: begin
            cmd.op    = sslg_pkg::OP_INIT_ND;
            val_raddr = {i_ff[IW-1:0], 2'd0};
            k_in      = 2'd0;
            state_in  = S_SRD;
         end
         S_SRD: begin
            cmd.op    = sslg_pkg::OP_LOAD_S;
            cmd.limb  = k_ff;
            val_raddr = {i_ff[IW-1:0], k_ff + 2'd1};
            if (k_ff == 2'd3) begin
               j_in     = '0;
               state_in = S_JNEXT;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         // basis product over the other shares
         S_JNEXT: begin
            x_raddr = j_ff[IW-1:0];
            priority if (j_ff == count_ff) begin
               state_in = S_MSN;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + CW'(1);
            end else begin
               state_in = S_JRD;
            end
         end
         S_JRD: begin
            if (stat.dup) begin
               err_in   = sslg_pkg::ST_DUP;
               k_in     = 2'd0;
               state_in = S_OUT;
            end else begin
               cmd.op   = sslg_pkg::OP_DIFF;
               state_in = S_MNUM;
            end
         end
         S_MNUM: begin
            cmd.op = sslg_pkg::OP_MUL_NUM;
            if (mul_fin) begin
               state_in = S_MDEN;
            end
         end
         S_MDEN: begin
            cmd.op = sslg_pkg::OP_MUL_DEN;
            if (mul_fin) begin
               j_in     = j_ff + CW'(1);
               state_in = S_JNEXT;
            end
         end
         // fold the term into yn / yd
         S_MSN: begin
            cmd.op = sslg_pkg::OP_MUL_SN;
            if (mul_fin) begin
               state_in = S_MT;
            end
         end
         S_MT: begin
            cmd.op = sslg_pkg::OP_MUL_T;
            if (mul_fin) begin
               state_in = S_MSY;
            end
         end
         S_MSY: begin
            cmd.op = sslg_pkg::OP_MUL_SY;
            if (mul_fin) begin
               state_in = S_ADDY;
            end
         end
         S_ADDY: begin
            cmd.op   = sslg_pkg::OP_ADD_Y;
            state_in = S_MYD;
         end
         S_MYD: begin
            cmd.op = sslg_pkg::OP_MUL_YD;
            if (mul_fin) begin
               i_in     = i_next;
               state_in = (i_next == count_ff) ? S_INITR : S_SHARE;
            end
         end
         // inverse of yd by square and multiply
         S_INITR: begin
            cmd.op   = sslg_pkg::OP_INIT_R;
            bit_in   = 8'd255;
            state_in = S_MRR;
         end
         S_MRR: begin
            cmd.op = sslg_pkg::OP_MUL_RR;
            if (mul_fin) begin
               priority if (sslg_pkg::EXP_PM2[bit_ff]) begin
                  state_in = S_MRY;
               end else if (bit_ff == 8'd0) begin
                  state_in = S_MFIN;
               end else begin
                  bit_in = bit_ff - 8'd1;
               end
            end
         end
         S_MRY: begin
            cmd.op = sslg_pkg::OP_MUL_RY;
            if (mul_fin) begin
               if (bit_ff == 8'd0) begin
                  state_in = S_MFIN;
               end else begin
                  bit_in   = bit_ff - 8'd1;
                  state_in = S_MRR;
               end
            end
         end
         S_MFIN: begin
            cmd.op = sslg_pkg::OP_MUL_YR;
            if (mul_fin) begin
               k_in     = 2'd0;
               state_in = S_OUT;
            end
         end
         // four result limbs
         S_OUT: begin
            rsp_valid = 1'b1;
            cmd.limb  = k_ff;
            if (rsp_ready) begin
               if (k_ff == 2'd3) begin
                  count_in = '0;
                  err_in   = sslg_pkg::ST_OK;
                  state_in = S_LOAD;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   assign rsp_limb_number = k_ff;
   assign rsp_status      = err_ff;
   assign rsp_last        = (k_ff == 2'd3);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         err_ff   <= sslg_pkg::ST_OK;
         run_ff   <= 1'b0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         err_ff   <= err_in;
         run_ff   <= run_in;
         k_ff     <= k_in;
      end
      i_ff   <= i_in;
      j_ff   <= j_in;
      bit_ff <= bit_in;
   end

endmodule

>>> design/shamir_share_lagrange_interpolator.sv
// Share limbs load one per cycle; after the last limb a range scan (S_RSET, an S_RRD read of
// each limb, S_RCMP) runs per share, then roughly (2n^2 + 2n + 506) modular multiplications.
// Only one share set is handled at a time; the bit-serial modular multiplier sets the evaluation time.
// Too many shares skips the scan; a value not below the prime ends it early; duplicate
// indices end evaluation early; four result limbs then follow, each held until rsp_ready.
// Reset (synchronous) clears share count, status and eval point; share stores are not cleared.
// ---------------------------------------------------------------------------
// shamir_share_lagrange_interpolator
// secret reconstruction by Lagrange interpolation over the 256-bit prime field
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module shamir_share_lagrange_interpolator #(
   parameter int MAX_SHARES = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sslg_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sslg_pkg::rsp_type rsp_payload,
   input  logic              csr_we,
   input  logic [15:0]       csr_wdata
);

   localparam int IW = (MAX_SHARES > 1) ? $clog2(MAX_SHARES) : 1;
   localparam int CW = $clog2(MAX_SHARES + 1);

   sslg_pkg::cmd_type  cmd;
   sslg_pkg::stat_type stat;
   logic [IW-1:0]      wr_slot;
   logic [IW+1:0]      val_raddr;
   logic [IW-1:0]      x_raddr;
   logic [63:0]        res_limb;
   logic [1:0]         rsp_limb_number;
   logic [1:0]         rsp_status;
   logic               rsp_last;

   sslg_ctrl #(.MAX_SHARES(MAX_SHARES), .IW(IW), .CW(CW)) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req             (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_limb_number (rsp_limb_number),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .stat            (stat),
      .cmd             (cmd),
      .wr_slot         (wr_slot),
      .val_raddr       (val_raddr),
      .x_raddr         (x_raddr)
   );

   sslg_datapath #(.MAX_SHARES(MAX_SHARES), .IW(IW)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req       (req_payload),
      .cmd       (cmd),
      .wr_slot   (wr_slot),
      .val_raddr (val_raddr),
      .x_raddr   (x_raddr),
      .stat      (stat),
      .res_limb  (res_limb)
   );

   // response assembly, value forced to zero on any error
   always_comb begin
      rsp_payload.result_limb        = (rsp_status == sslg_pkg::ST_OK) ? res_limb : '0;
      rsp_payload.result_limb_number = rsp_limb_number;
      rsp_payload.status             = rsp_status;
      rsp_payload.last_limb          = rsp_last;
   end

   // checks
   `SSLG_ASSERT_ALWAYS(a_no_overlap, !(req_ready && rsp_valid), "load and response overlap")
   `SSLG_ASSERT_ALWAYS(a_err_zero, !rsp_valid || (rsp_status == sslg_pkg::ST_OK) || (rsp_payload.result_limb == 64'd0), "error result not zero")
   `SSLG_ASSERT_NEXT(a_back_to_load, rsp_valid && rsp_ready && rsp_last, req_ready, "no return to load after last limb")
   `SSLG_ASSERT_ALWAYS(a_last_pos, !rsp_valid || (rsp_last == (rsp_limb_number == 2'd3)), "last limb flag misplaced")

endmodule
